@@ src/scme_pkg.sv @@
// Shared types and constants for the scan change to MIDI note encoder.
package scme_pkg;

    localparam int BYTES       = 8;
    localparam int IDX_W       = 4;
    localparam int SLOT_W      = (BYTES > 1) ? $clog2(BYTES) : 1;
    localparam int SCAN_W      = 8;
    localparam int BIT_W       = 3;
    localparam int STATUS_W    = 8;
    localparam int NOTE_W      = 8;
    localparam int VEL_W       = 7;
    localparam int CHAN_W      = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;

    localparam logic [STATUS_W-1:0] CMD_NOTE_ON  = 8'h90;
    localparam logic [STATUS_W-1:0] CMD_NOTE_OFF = 8'h80;
    localparam logic [STATUS_W-1:0] CMD_NIBBLE   = 8'hF0;
    localparam logic [VEL_W-1:0]    VEL_DEFAULT  = 7'h69;
    localparam logic [IDX_W-1:0]    SWAP_INDEX   = 4'd2;
    localparam int                  SWAP_LOW     = 2;
    localparam int                  SWAP_HIGH    = 6;

    localparam logic [CFG_IDX_W-1:0] REG_MIDI_CHANNEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_VELOCITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SET_NOTE_ON   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_FIX      = 2'd3;

    typedef struct packed {
        logic [CHAN_W-1:0] midi_channel;
        logic [VEL_W-1:0]  note_velocity;
        logic              set_sends_note_on;
        logic              swap_fix_enable;
    } t_cfg;

endpackage

@@ src/scme_if.sv @@
// Channel interfaces for scan items and MIDI note messages.
interface scme_in_if;
    logic                            valid;
    logic                            ready;
    logic [scme_pkg::IDX_W-1:0]      byte_index;
    logic [scme_pkg::SCAN_W-1:0]     scan_value;

    modport source (output valid, output byte_index, output scan_value, input ready);
    modport sink   (input valid, input byte_index, input scan_value, output ready);
endinterface

interface scme_out_if;
    logic                            valid;
    logic                            ready;
    logic [scme_pkg::STATUS_W-1:0]   status_byte;
    logic [scme_pkg::NOTE_W-1:0]     note_number;
    logic [scme_pkg::VEL_W-1:0]      velocity_byte;
    logic                            last_message;

    modport source (output valid, output status_byte, output note_number,
                    output velocity_byte, output last_message, input ready);
    modport sink   (input valid, input status_byte, input note_number,
                    input velocity_byte, input last_message, output ready);
endinterface

@@ src/scme_cfg.sv @@
// Configuration register file of the MIDI note encoder.
module scme_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [scme_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [scme_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output scme_pkg::t_cfg                      o_cfg
);

    scme_pkg::t_cfg r_cfg;
    scme_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                scme_pkg::REG_MIDI_CHANNEL:
                    n_cfg.midi_channel = i_cfg_data[scme_pkg::CHAN_W-1:0];
                scme_pkg::REG_NOTE_VELOCITY:
                    n_cfg.note_velocity = i_cfg_data[scme_pkg::VEL_W-1:0];
                scme_pkg::REG_SET_NOTE_ON:
                    n_cfg.set_sends_note_on = i_cfg_data[0];
                scme_pkg::REG_SWAP_FIX:
                    n_cfg.swap_fix_enable = i_cfg_data[0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.midi_channel      <= '0;
            r_cfg.note_velocity     <= scme_pkg::VEL_DEFAULT;
            r_cfg.set_sends_note_on <= 1'b0;
            r_cfg.swap_fix_enable   <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/scan_change_to_midi_encoder_unit.sv @@
// Top level: scan byte change detection and MIDI note message sequencer.
// A scan byte is taken only in the idle state; a changed byte holds off further scan items
// until the message for its highest changed bit is loaded, while an unchanged or out-of-range
// byte leaves the unit idle. A bit walker tests one bit position per cycle and stalls on
// output back-pressure.
// Reset clears the previous-scan store and the sequencer and loads the default configuration.
module scan_change_to_midi_encoder_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [scme_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [scme_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    scme_in_if.sink                             i_in,
    scme_out_if.source                          o_out
);

    typedef enum logic {S_IDLE, S_SCAN} t_state;

    scme_pkg::t_cfg w_cfg;

    t_state                             r_state;
    logic [scme_pkg::SCAN_W-1:0]        r_prev [scme_pkg::BYTES];
    logic [scme_pkg::SCAN_W-1:0]        r_diff;
    logic [scme_pkg::SCAN_W-1:0]        r_val;
    logic [scme_pkg::IDX_W-1:0]         r_idx;
    logic [scme_pkg::BIT_W-1:0]         r_bit;
    logic                               r_out_valid;
    logic [scme_pkg::STATUS_W-1:0]      r_status;
    logic [scme_pkg::NOTE_W-1:0]        r_note;
    logic [scme_pkg::VEL_W-1:0]         r_vel;
    logic                               r_last;

    logic [scme_pkg::SLOT_W-1:0]        w_slot;
    logic [scme_pkg::SCAN_W-1:0]        w_val;
    logic [scme_pkg::SCAN_W-1:0]        w_new_diff;
    logic [scme_pkg::SCAN_W-1:0]        w_rest;
    logic                               w_in_ok;
    logic                               w_out_free;
    logic                               w_hit;
    logic                               w_emit;
    logic                               w_on;
    logic [scme_pkg::STATUS_W-1:0]      w_cmd;

    scme_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign w_slot     = i_in.byte_index[scme_pkg::SLOT_W-1:0];
    assign w_in_ok    = ({1'b0, i_in.byte_index} < (scme_pkg::IDX_W+1)'(scme_pkg::BYTES));

    always_comb begin
        w_val = i_in.scan_value;
        if (w_cfg.swap_fix_enable && (i_in.byte_index == scme_pkg::SWAP_INDEX)) begin
            w_val[scme_pkg::SWAP_LOW]  = i_in.scan_value[scme_pkg::SWAP_HIGH];
            w_val[scme_pkg::SWAP_HIGH] = i_in.scan_value[scme_pkg::SWAP_LOW];
        end
    end

    assign w_new_diff = w_val ^ r_prev[w_slot];

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_hit      = r_diff[r_bit];
    assign w_emit     = (r_state == S_SCAN) && w_hit && w_out_free;
    assign w_on       = (r_val[r_bit] == w_cfg.set_sends_note_on);
    assign w_cmd      = w_on ? scme_pkg::CMD_NOTE_ON : scme_pkg::CMD_NOTE_OFF;

    always_comb begin
        w_rest        = r_diff;
        w_rest[r_bit] = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < scme_pkg::BYTES; i++) begin
                r_prev[i] <= '0;
            end
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid && w_in_ok) begin
                        r_prev[w_slot] <= w_val;
                        r_diff         <= w_new_diff;
                        r_val          <= w_val;
                        r_idx          <= i_in.byte_index;
                        r_bit          <= '0;
                        if (w_new_diff != '0) begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (!w_hit) begin
                        r_bit <= r_bit + 1'b1;
                    end else if (w_out_free) begin
                        r_status    <= (w_cmd & scme_pkg::CMD_NIBBLE)
                                     | {{(scme_pkg::STATUS_W-scme_pkg::CHAN_W){1'b0}},
                                        w_cfg.midi_channel};
                        r_note      <= {{(scme_pkg::NOTE_W-scme_pkg::IDX_W-scme_pkg::BIT_W){1'b0}},
                                        r_idx, r_bit}
                                     + scme_pkg::NOTE_W'(1);
                        r_vel       <= w_cfg.note_velocity;
                        r_last      <= (w_rest == '0);
                        r_diff      <= w_rest;
                        r_bit       <= r_bit + 1'b1;
                        if (w_rest == '0) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status_byte   = r_status;
    assign o_out.note_number   = r_note;
    assign o_out.velocity_byte = r_vel;
    assign o_out.last_message  = r_last;

endmodule
